>>> rtl/sgcw_pkg.sv
// ----------------------------------------------------------------------------
// sgcw_pkg
// Shared constants, codes and control types of the segment grid cell walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgcw_pkg;

  localparam int GRID_SIDE_DEF = 64;
  localparam int MAX_RUN_DEF   = 64;

  localparam int COORD_W   = 32;
  localparam int CS_W      = 31;
  localparam int CA_CFG_W  = 7;
  localparam int IDX_W     = 12;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = 4 * COORD_W;
  localparam int OUT_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_ACROSS = 2'd2;

  localparam logic [COORD_W-1:0]  ORIGIN_RST       = 32'hFFE0_0000;
  localparam logic [CS_W-1:0]     CELL_SIZE_RST    = 31'd65536;
  localparam logic [CA_CFG_W-1:0] CELLS_ACROSS_RST = 7'd64;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_TRUNC = 2'd2;

  // walk step phases
  localparam logic [2:0] PH_NONE = 3'd0;
  localparam logic [2:0] PH_EX   = 3'd1;
  localparam logic [2:0] PH_YB   = 3'd2;
  localparam logic [2:0] PH_YT   = 3'd3;
  localparam logic [2:0] PH_P0   = 3'd4;
  localparam logic [2:0] PH_P1   = 3'd5;
  localparam logic [2:0] PH_P2   = 3'd6;
  localparam logic [2:0] PH_DEC  = 3'd7;

  typedef struct packed {
    logic       load;
    logic       div_start;
    logic       div_store;
    logic [1:0] div_sel;
    logic       init;
    logic [2:0] phase;
    logic       emit;
    logic       emit_err;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic err_early;
    logic oob;
    logic out_free;
    logic last_cell;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/sgcw_div.sv
// ----------------------------------------------------------------------------
// sgcw_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgcw_div #(
  parameter int DW = 32,
  parameter int VW = 31
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic      [DW-1:0] quo,
  output logic               done
);

  localparam int CNW = $clog2(DW + 1);

  logic [DW-1:0]  rem_r, rem_nxt;
  logic [DW-1:0]  quo_r, quo_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [DW:0]    trial;
  logic [DW:0]    dvs;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[DW-1]};
    dvs      = (DW + 1)'(divisor);
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = CNW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= dvs) begin
        rem_nxt = DW'(trial - dvs);
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNW'(1);
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

`default_nettype wire

>>> rtl/sgcw_dp.sv
// ----------------------------------------------------------------------------
// sgcw_dp
// Datapath: config registers, endpoint cells, edge crossing test, walk
// position and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgcw_dp #(
  parameter int GRID_SIDE = sgcw_pkg::GRID_SIDE_DEF,
  parameter int MAX_RUN   = sgcw_pkg::MAX_RUN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire sgcw_pkg::cmd_t                  cmd,
  output sgcw_pkg::stat_t                      stat,
  input  wire logic [sgcw_pkg::IN_W-1:0]       in_tdata,
  input  wire logic                            cfg_wr,
  input  wire logic [sgcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sgcw_pkg::COORD_W-1:0]    cfg_data,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic      [sgcw_pkg::OUT_W-1:0]      out_tdata,
  output logic                                 out_tlast,
  output logic      [sgcw_pkg::ST_W-1:0]       out_tuser
);

  localparam int CW  = $clog2(GRID_SIDE);
  localparam int CAW = $clog2(GRID_SIDE + 1);
  localparam int SW  = CW + 2;
  localparam int NW  = $clog2(MAX_RUN);
  localparam int EXW = sgcw_pkg::CS_W + CW + 1;
  localparam int IW  = CW + CAW + 1;
  localparam int DW  = sgcw_pkg::COORD_W;

  logic [DW-1:0]                 origin_r;
  logic [sgcw_pkg::CS_W-1:0]     cell_size_r;
  logic [sgcw_pkg::CA_CFG_W-1:0] cells_across_r;

  logic [sgcw_pkg::CS_W-1:0] cs;
  logic [CAW-1:0]            ca;

  logic [DW-1:0] coord_r [0:3];
  logic [CW-1:0] qv_r    [0:3];
  logic          err_early_r, oob_r;

  logic [DW-1:0] ad_r, at_r, emag_r, b0mag_r, tmag_r;
  logic          eneg_r, b0neg_r, tneg_r, in_rng_r;
  logic [DW-1:0] lo_r, hi_r;
  logic [EXW-1:0] ex_r, yb_r, yt_r;
  logic [2*DW-1:0] p0_r, p1_r, p2_r;
  logic [CW-1:0] x_r, y_r;
  logic          xneg_r, yneg_r;
  logic [SW-1:0] rem_r;
  logic [NW-1:0] cnt_r;

  logic                        ov_r;
  logic [sgcw_pkg::IDX_W-1:0]  oidx_r;
  logic                        olast_r;
  logic [sgcw_pkg::ST_W-1:0]   ost_r;

  logic [DW-1:0] quo;
  logic          div_done;

  logic [DW+1:0]   du [0:3];
  logic [CW:0]     xm;
  logic [EXW:0]    dyb, dyt;
  logic [DW:0]     dad, de;
  logic [CW-1:0]   dc, dr;
  logic            meets, stepx, is_max;
  logic [IW-1:0]   idx_w;
  logic [DW-1:0]   org;

  function automatic logic prod_le(input logic pn, input logic [2*DW-1:0] pm,
                                   input logic qn, input logic [2*DW-1:0] qm);
    logic r;
    if (pn != qn) r = pn;
    else if (!pn) r = (pm <= qm);
    else          r = (pm >= qm);
    return r;
  endfunction

  assign cs = (cell_size_r == '0) ? sgcw_pkg::CS_W'(1) : cell_size_r;
  assign ca = (32'(cells_across_r) > GRID_SIDE) ? CAW'(GRID_SIDE) : CAW'(cells_across_r);
  assign org = origin_r;

  sgcw_div #(.DW(DW), .VW(sgcw_pkg::CS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (coord_r[cmd.div_sel]),
    .divisor  (cs),
    .quo      (quo),
    .done     (div_done)
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      du[k] = {{2{in_tdata[k*DW+DW-1]}}, in_tdata[k*DW +: DW]} - {{2{org[DW-1]}}, org};
    end
    xm    = xneg_r ? {1'b0, x_r} : ({1'b0, x_r} + (CW + 1)'(1));
    dyb   = {1'b0, yb_r} - (EXW + 1)'(coord_r[1]);
    dyt   = {1'b0, yt_r} - (EXW + 1)'(coord_r[1]);
    dad   = {1'b0, coord_r[2]} - {1'b0, coord_r[0]};
    de    = {1'b0, coord_r[3]} - {1'b0, coord_r[1]};
    dc    = (qv_r[2] < qv_r[0]) ? (qv_r[0] - qv_r[2]) : (qv_r[2] - qv_r[0]);
    dr    = (qv_r[3] < qv_r[1]) ? (qv_r[1] - qv_r[3]) : (qv_r[3] - qv_r[1]);
    meets = in_rng_r
          && prod_le(b0neg_r && (ad_r != '0), p0_r, eneg_r && (at_r != '0), p1_r)
          && prod_le(eneg_r && (at_r != '0), p1_r, tneg_r && (ad_r != '0), p2_r);
    if (x_r == qv_r[2])      stepx = 1'b0;
    else if (y_r == qv_r[3]) stepx = 1'b1;
    else                     stepx = meets;
    is_max = (cnt_r == NW'(MAX_RUN - 1));
    idx_w  = IW'(y_r) * IW'(ca) + IW'(x_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r       <= sgcw_pkg::ORIGIN_RST;
      cell_size_r    <= sgcw_pkg::CELL_SIZE_RST;
      cells_across_r <= sgcw_pkg::CELLS_ACROSS_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        sgcw_pkg::REG_ORIGIN:       origin_r       <= cfg_data;
        sgcw_pkg::REG_CELL_SIZE:    cell_size_r    <= cfg_data[sgcw_pkg::CS_W-1:0];
        sgcw_pkg::REG_CELLS_ACROSS: cells_across_r <= cfg_data[sgcw_pkg::CA_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 4; k++) coord_r[k] <= du[k][DW-1:0];
      err_early_r <= du[0][DW+1] | du[1][DW+1] | du[2][DW+1] | du[3][DW+1]
                   | (ca == '0);
      oob_r <= 1'b0;
    end
    if (cmd.div_store) begin
      qv_r[cmd.div_sel] <= quo[CW-1:0];
      if (quo >= DW'(ca)) oob_r <= 1'b1;
    end
    if (cmd.init) begin
      x_r    <= qv_r[0];
      y_r    <= qv_r[1];
      xneg_r <= qv_r[2] < qv_r[0];
      yneg_r <= qv_r[3] < qv_r[1];
      rem_r  <= SW'(dc) + SW'(dr);
      cnt_r  <= '0;
      ad_r   <= dad[DW] ? DW'(-dad) : dad[DW-1:0];
      eneg_r <= de[DW];
      emag_r <= de[DW] ? DW'(-de) : de[DW-1:0];
      lo_r   <= dad[DW] ? coord_r[2] : coord_r[0];
      hi_r   <= dad[DW] ? coord_r[0] : coord_r[2];
    end
    case (cmd.phase)
      sgcw_pkg::PH_EX: ex_r <= EXW'(cs) * EXW'(xm);
      sgcw_pkg::PH_YB: begin
        yb_r     <= EXW'(cs) * EXW'(y_r);
        in_rng_r <= (ex_r >= EXW'(lo_r)) && (ex_r <= EXW'(hi_r));
        at_r     <= (ex_r >= EXW'(coord_r[0])) ? DW'(ex_r - EXW'(coord_r[0]))
                                                 : DW'(EXW'(coord_r[0]) - ex_r);
      end
      sgcw_pkg::PH_YT: begin
        yt_r    <= yb_r + EXW'(cs);
        b0neg_r <= dyb[EXW];
        b0mag_r <= dyb[EXW] ? DW'(-dyb) : dyb[DW-1:0];
      end
      sgcw_pkg::PH_P0: begin
        tneg_r <= dyt[EXW];
        if (dyt[EXW])               tmag_r <= DW'(-dyt);
        else if (|dyt[EXW-1:DW])    tmag_r <= '1;
        else                        tmag_r <= dyt[DW-1:0];
        p0_r <= (2 * DW)'(ad_r) * (2 * DW)'(b0mag_r);
      end
      sgcw_pkg::PH_P1: p1_r <= (2 * DW)'(at_r) * (2 * DW)'(emag_r);
      sgcw_pkg::PH_P2: p2_r <= (2 * DW)'(ad_r) * (2 * DW)'(tmag_r);
      sgcw_pkg::PH_DEC: begin
        if (stepx) x_r <= xneg_r ? (x_r - CW'(1)) : (x_r + CW'(1));
        else       y_r <= yneg_r ? (y_r - CW'(1)) : (y_r + CW'(1));
        rem_r <= rem_r - SW'(1);
      end
      default: ;
    endcase
    if (cmd.emit) begin
      cnt_r   <= cnt_r + NW'(1);
      oidx_r  <= sgcw_pkg::IDX_W'(idx_w);
      olast_r <= (rem_r == '0) || is_max;
      ost_r   <= (is_max && (rem_r != '0)) ? sgcw_pkg::ST_TRUNC : sgcw_pkg::ST_OK;
    end else if (cmd.emit_err) begin
      oidx_r  <= '0;
      olast_r <= 1'b1;
      ost_r   <= sgcw_pkg::ST_RANGE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_err) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  assign stat.div_done  = div_done;
  assign stat.err_early = err_early_r;
  assign stat.oob       = oob_r;
  assign stat.out_free  = !ov_r || out_tready;
  assign stat.last_cell = (rem_r == '0) || is_max;

  assign out_tvalid = ov_r;
  assign out_tdata  = sgcw_pkg::OUT_W'(oidx_r);
  assign out_tlast  = olast_r;
  assign out_tuser  = ost_r;

endmodule

`default_nettype wire

>>> rtl/sgcw_ctrl.sv
// ----------------------------------------------------------------------------
// sgcw_ctrl
// Sequencer: endpoint division, range check, cell emission and step phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgcw_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output sgcw_pkg::cmd_t       cmd,
  input  wire sgcw_pkg::stat_t stat
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHK    = 4'd1;
  localparam logic [3:0] S_DSTART = 4'd2;
  localparam logic [3:0] S_DWAIT  = 4'd3;
  localparam logic [3:0] S_RANGE  = 4'd4;
  localparam logic [3:0] S_INIT   = 4'd5;
  localparam logic [3:0] S_EMIT   = 4'd6;
  localparam logic [3:0] S_WALK   = 4'd7;
  localparam logic [3:0] S_ERR    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic [2:0] ph_r, ph_nxt;

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    ph_nxt    = ph_r;
    cmd       = '0;
    cmd.div_sel = sel_r;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        sel_nxt   = 2'd0;
        state_nxt = stat.err_early ? S_ERR : S_DSTART;
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          sel_nxt       = sel_r + 2'd1;
          state_nxt     = (sel_r == 2'd3) ? S_RANGE : S_DSTART;
        end
      end
      S_RANGE: state_nxt = stat.oob ? S_ERR : S_INIT;
      S_INIT: begin
        cmd.init  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          ph_nxt   = sgcw_pkg::PH_EX;
          state_nxt = stat.last_cell ? S_IDLE : S_WALK;
        end
      end
      S_WALK: begin
        cmd.phase = ph_r;
        ph_nxt    = ph_r + 3'd1;
        if (ph_r == sgcw_pkg::PH_DEC) state_nxt = S_EMIT;
      end
      S_ERR: begin
        if (stat.out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
    ph_r  <= ph_nxt;
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/segment_grid_cell_walk_unit.sv
// ----------------------------------------------------------------------------
// segment_grid_cell_walk_unit
// Lists the square-grid cells crossed by a Q16.16 line segment.
// ----------------------------------------------------------------------------
// One segment at a time. Setup divides the four relative coordinates by the
// cell size on a shared one-bit-per-cycle divider, one after the other, before
// the first cell. Each further cell passes the step phases of the edge test,
// one multiply stage per phase for its three 32x32 products, and waits while
// the output is stalled. An endpoint outside the grid gives one result with
// status 1; runs longer than MAX_RUN cells end with status 2.
`timescale 1ns / 1ps
`default_nettype none

module segment_grid_cell_walk_unit #(
  parameter int GRID_SIDE = sgcw_pkg::GRID_SIDE_DEF,
  parameter int MAX_RUN   = sgcw_pkg::MAX_RUN_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // start_x, start_y, end_x, end_y
  input  wire logic [sgcw_pkg::IN_W-1:0]           in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // cell_index, zero pad
  output logic      [sgcw_pkg::OUT_W-1:0]          out_tdata,
  output logic                                     out_tlast,
  // status
  output logic      [sgcw_pkg::ST_W-1:0]           out_tuser,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [sgcw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sgcw_pkg::COORD_W-1:0]        cfg_data
);

  sgcw_pkg::cmd_t  cmd;
  sgcw_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  sgcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sgcw_dp #(.GRID_SIDE(GRID_SIDE), .MAX_RUN(MAX_RUN)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == sgcw_pkg::ST_RANGE) |-> out_tlast)
    else $error("range error result without last");

  a_trunc_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == sgcw_pkg::ST_TRUNC) |-> out_tlast)
    else $error("truncated run result without last");

  a_one_seg: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second segment taken during setup");
`endif

endmodule

`default_nettype wire
